[rtl/core/u8u16_pkg.sv]
// ============================================================================
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ============================================================================
package u8u16_pkg;

    // Configuration port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [0:0]  REG_UNIT_LIMIT = 1'b0;
    localparam logic [15:0] UNIT_LIMIT_RST = 16'd255;

    // Code point constants
    localparam logic [15:0] CP_REPL     = 16'hFFFD;
    localparam logic [20:0] CP_MIN3     = 21'h000800;
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] CP_MIN4     = 21'h010000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Main action of one queued item
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_UNIT,
        KIND_PAIR
    } kind_t;

    // One classified item: replacement units first, then the main action,
    // then the terminator
    typedef struct packed {
        logic [2:0]  nfffd;
        kind_t       kind;
        logic [20:0] cp;
        logic        term;
    } rec_t;

    // Step of the back end on the queue head
    typedef enum logic [2:0] {
        ACT_FFFD,
        ACT_UNIT,
        ACT_HI,
        ACT_LO,
        ACT_END
    } act_t;

    // Sequence length from a lead byte, 0 when the byte cannot lead
    function automatic logic [2:0] lead_len(input logic [7:0] lead);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (lead inside {[8'hC2:8'hDF]})
            begin
                len = 3'd2;
            end
            else if (lead inside {[8'hE0:8'hEF]})
            begin
                len = 3'd3;
            end
            else if (lead inside {[8'hF0:8'hF4]})
            begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

endpackage

[rtl/core/u8u16_front.sv]
// ============================================================================
// u8u16_front
// Takes one byte per cycle unless the queue is full, tracks held bytes of a
// sequence and queues an item describing the units each byte yields, if any.
// ============================================================================
module u8u16_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              last,
    input  logic              q_full,
    output logic              q_push,
    output u8u16_pkg::rec_t   q_rec
);
    import u8u16_pkg::*;

    logic [7:0]  pend_reg [3];
    logic [7:0]  pend_next [3];
    logic [1:0]  pcount_reg;
    logic [1:0]  pcount_next;
    logic        ended_reg;
    logic        ended_next;

    logic        accept;
    logic        is_cont;
    logic [2:0]  seq_len;
    logic [20:0] cp2;
    logic [20:0] cp3;
    logic [20:0] cp4;
    logic [20:0] cp_fin;
    logic        ok_fin;
    logic [2:0]  fffd_v;
    kind_t       kind_v;
    logic [20:0] cp_v;
    logic        term_v;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign seq_len  = lead_len(pend_reg[0]);

    // Code point candidates for each sequence length
    assign cp2 = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
    assign cp3 = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]};
    assign cp4 = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], in_byte[5:0]};

    always_comb
    begin
        case (seq_len)
            3'd2:
            begin
                cp_fin = cp2;
                ok_fin = 1'b1;
            end
            3'd3:
            begin
                cp_fin = cp3;
                ok_fin = (cp3 >= CP_MIN3) && !((cp3 >= CP_SURR_LO) && (cp3 <= CP_SURR_HI));
            end
            default:
            begin
                cp_fin = cp4;
                ok_fin = (cp4 >= CP_MIN4) && (cp4 <= CP_MAX);
            end
        endcase
    end

    // Classify the byte
    always_comb
    begin
        fffd_v      = 3'd0;
        kind_v      = KIND_NONE;
        cp_v        = 21'd0;
        term_v      = 1'b0;
        pend_next   = pend_reg;
        pcount_next = pcount_reg;
        if (in_byte == 8'd0)
        begin
            // zero byte: flush and end
            fffd_v      = {1'b0, pcount_reg};
            pcount_next = 2'd0;
            term_v      = 1'b1;
        end
        else
        begin
            if ((pcount_reg != 2'd0) && is_cont)
            begin
                if (({1'b0, pcount_reg} + 3'd1) >= seq_len)
                begin
                    // sequence complete
                    pcount_next = 2'd0;
                    if (!ok_fin)
                    begin
                        fffd_v = seq_len;
                    end
                    else if (cp_fin <= CP_BMP_MAX)
                    begin
                        kind_v = KIND_UNIT;
                        cp_v   = cp_fin;
                    end
                    else
                    begin
                        kind_v = KIND_PAIR;
                        cp_v   = cp_fin;
                    end
                end
                else
                begin
                    pend_next[pcount_reg] = in_byte;
                    pcount_next           = pcount_reg + 2'd1;
                end
            end
            else if (is_cont)
            begin
                // lone continuation byte
                fffd_v = 3'd1;
            end
            else
            begin
                // fresh byte, any held bytes are flushed first
                fffd_v      = {1'b0, pcount_reg};
                pcount_next = 2'd0;
                if (!in_byte[7])
                begin
                    kind_v = KIND_UNIT;
                    cp_v   = {13'd0, in_byte};
                end
                else if (lead_len(in_byte) != 3'd0)
                begin
                    pend_next[0] = in_byte;
                    pcount_next  = 2'd1;
                end
                else
                begin
                    fffd_v = fffd_v + 3'd1;
                end
            end
            if (last)
            begin
                fffd_v      = fffd_v + {1'b0, pcount_next};
                pcount_next = 2'd0;
                term_v      = 1'b1;
            end
        end
    end

    assign ended_next = ended_reg || term_v;

    assign q_rec.nfffd = fffd_v;
    assign q_rec.kind  = kind_v;
    assign q_rec.cp    = cp_v;
    assign q_rec.term  = term_v;
    assign q_push = accept && !ended_reg &&
                    ((fffd_v != 3'd0) || (kind_v != KIND_NONE) || term_v);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 2'd0;
            ended_reg  <= 1'b0;
        end
        else if (accept && !ended_reg)
        begin
            pcount_reg <= pcount_next;
            ended_reg  <= ended_next;
        end
    end

    // Held bytes
    always_ff @(posedge clk)
    begin
        if (accept && !ended_reg)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

[rtl/core/u8u16_queue.sv]
// ============================================================================
// u8u16_queue
// Short queue of classified items between the front and the back end.
// ============================================================================
module u8u16_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u8u16_pkg::rec_t   push_rec,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output u8u16_pkg::rec_t   head_rec
);
    import u8u16_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    rec_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[rtl/core/u8u16_back.sv]
// ============================================================================
// u8u16_back
// Steps through the queue head one unit per cycle while the output is not
// stalled, applies the unit limit and drives the registered result channel.
// ============================================================================
module u8u16_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  u8u16_pkg::rec_t   head_rec,
    output logic              pop,
    input  logic [15:0]       unit_limit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       code_unit,
    output logic              is_end
);
    import u8u16_pkg::*;

    logic [2:0]  done_cnt_reg;
    logic [2:0]  done_cnt_next;
    logic        main_done_reg;
    logic        main_done_next;
    logic        lo_pend_reg;
    logic        lo_pend_next;
    logic [15:0] written_reg;
    logic [15:0] written_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] unit_reg;
    logic [15:0] unit_next;
    logic        end_reg;
    logic        end_next;

    act_t        act;
    logic        advance;
    logic        emit;
    logic        rec_done;
    logic        fits1;
    logic        fits2;
    logic [20:0] v_full;
    logic [15:0] act_unit;
    logic        act_term;

    assign advance = head_valid && (!out_valid_reg || !out_stall);
    assign v_full  = head_rec.cp - CP_MIN4;
    assign fits1   = (written_reg < unit_limit);
    assign fits2   = (({1'b0, written_reg} + 17'd2) <= {1'b0, unit_limit});

    // Pick the next step on the head item
    always_comb
    begin
        if (done_cnt_reg < head_rec.nfffd)
        begin
            act = ACT_FFFD;
        end
        else if (!main_done_reg && (head_rec.kind == KIND_UNIT))
        begin
            act = ACT_UNIT;
        end
        else if (!main_done_reg && (head_rec.kind == KIND_PAIR))
        begin
            act = ACT_HI;
        end
        else if (lo_pend_reg)
        begin
            act = ACT_LO;
        end
        else
        begin
            act = ACT_END;
        end
    end

    // Step outputs: unit value, limit check, end of item
    always_comb
    begin
        emit         = 1'b0;
        act_unit     = CP_REPL;
        act_term     = 1'b0;
        rec_done     = 1'b0;
        written_next = written_reg;
        stopped_next = stopped_reg;
        case (act)
            ACT_FFFD, ACT_UNIT:
            begin
                act_unit = (act == ACT_FFFD) ? CP_REPL : head_rec.cp[15:0];
                if (!stopped_reg)
                begin
                    if (fits1)
                    begin
                        emit         = 1'b1;
                        written_next = written_reg + 16'd1;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                if (act == ACT_FFFD)
                begin
                    rec_done = ((done_cnt_reg + 3'd1) == head_rec.nfffd) &&
                               (head_rec.kind == KIND_NONE) && !head_rec.term;
                end
                else
                begin
                    rec_done = !head_rec.term;
                end
            end
            ACT_HI:
            begin
                act_unit = HI_SURR_BASE + {6'd0, v_full[19:10]};
                if (!stopped_reg)
                begin
                    if (fits2)
                    begin
                        emit         = 1'b1;
                        written_next = written_reg + 16'd2;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                rec_done = !emit && !head_rec.term;
            end
            ACT_LO:
            begin
                act_unit = LO_SURR_BASE + {6'd0, v_full[9:0]};
                emit     = 1'b1;
                rec_done = !head_rec.term;
            end
            ACT_END:
            begin
                act_unit = 16'd0;
                act_term = 1'b1;
                emit     = 1'b1;
                rec_done = 1'b1;
            end
            default:
            begin
                rec_done = 1'b1;
            end
        endcase
    end

    // Sequencer state for the head item
    always_comb
    begin
        done_cnt_next  = done_cnt_reg;
        main_done_next = main_done_reg;
        lo_pend_next   = lo_pend_reg;
        if (rec_done)
        begin
            done_cnt_next  = 3'd0;
            main_done_next = 1'b0;
            lo_pend_next   = 1'b0;
        end
        else
        begin
            case (act)
                ACT_FFFD:
                begin
                    done_cnt_next = done_cnt_reg + 3'd1;
                end
                ACT_UNIT:
                begin
                    main_done_next = 1'b1;
                end
                ACT_HI:
                begin
                    main_done_next = 1'b1;
                    lo_pend_next   = emit;
                end
                ACT_LO:
                begin
                    lo_pend_next = 1'b0;
                end
                default:
                begin
                    lo_pend_next = lo_pend_reg;
                end
            endcase
        end
    end

    assign pop = advance && rec_done;

    // Output register
    assign out_valid_next = advance ? emit : (out_valid_reg && out_stall);
    assign unit_next      = (advance && emit) ? act_unit : unit_reg;
    assign end_next       = (advance && emit) ? act_term : end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_cnt_reg  <= 3'd0;
            main_done_reg <= 1'b0;
            lo_pend_reg   <= 1'b0;
            written_reg   <= 16'd0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                done_cnt_reg  <= done_cnt_next;
                main_done_reg <= main_done_next;
                lo_pend_reg   <= lo_pend_next;
                written_reg   <= written_next;
                stopped_reg   <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        end_reg  <= end_next;
    end

    assign out_valid = out_valid_reg;
    assign code_unit = unit_reg;
    assign is_end    = end_reg;

endmodule

[rtl/core/utf8_to_utf16_transcoder_top.sv]
// ============================================================================
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out, with a unit limit register.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / in_byte / last) takes one UTF-8 byte
//   per item. A zero byte or a byte with last set ends the string.
//   Output channel (out_valid / out_stall / code_unit / is_end) gives one
//   UTF-16 code unit per item; the string closes with an item that has
//   is_end set and code_unit zero. Bytes after the end are taken and dropped.
//   Register unit_limit sits at APB address 0; write it only while idle.
// Timing:
//   A byte is classified in the cycle it is taken; its first unit passes
//   through a queue entry and the output register. One byte per cycle is
//   sustained while each byte yields at most one unit and the output is not
//   stalled. A byte holds the sequencer one step per unit it emits or drops
//   at the limit (a dropped pair takes one) plus one for a terminator; a
//   four-entry queue between classifier and sequencer absorbs such bursts.
// Reset and stall:
//   rst_n clears the held bytes, unit count, stop and end flags; the limit
//   returns to 255. A stalled output holds its item; when the queue fills,
//   in_stall rises until the sequencer drains an entry.
// ============================================================================
module utf8_to_utf16_transcoder_top
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8u16_pkg::ADDR_W-1:0]    paddr,
    input  logic [u8u16_pkg::DATA_W-1:0]    pwdata,
    output logic [u8u16_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    // byte input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    input  logic                            last,
    // unit output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     code_unit,
    output logic                            is_end
);
    import u8u16_pkg::*;

    logic [15:0] unit_limit_reg;
    logic [15:0] unit_limit_next;
    logic        cfg_wr;
    logic        q_full;
    logic        q_push;
    rec_t        q_rec;
    logic        q_pop;
    logic        head_valid;
    rec_t        head_rec;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2:2] == REG_UNIT_LIMIT);
    assign unit_limit_next = cfg_wr ? pwdata[15:0] : unit_limit_reg;
    assign prdata = (paddr[2:2] == REG_UNIT_LIMIT) ?
                    {{(DATA_W - 16){1'b0}}, unit_limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_limit_reg <= UNIT_LIMIT_RST;
        end
        else
        begin
            unit_limit_reg <= unit_limit_next;
        end
    end

    u8u16_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .last     (last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_rec)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    u8u16_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (q_pop),
        .unit_limit (unit_limit_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_unit  (code_unit),
        .is_end     (is_end)
    );

endmodule

[rtl/core/u8u16_checker.sv]
// ============================================================================
// u8u16_checker
// Port-level checks on the transcoder output channel.
// ============================================================================
module u8u16_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] code_unit,
    input  logic        is_end
);
    import u8u16_pkg::*;

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(is_end))
        else $error("output item changed under stall");

    // Terminator carries a zero unit
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> code_unit == 16'd0)
        else $error("terminator with nonzero code unit");

    // A taken high surrogate is followed at once by a low surrogate
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !is_end &&
        (code_unit >= HI_SURR_BASE) && (code_unit < LO_SURR_BASE)
        |=> out_valid && !is_end && (code_unit >= LO_SURR_BASE) &&
            (code_unit <= 16'hDFFF))
        else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_checker (.*);

[dv/utf8_to_utf16_transcoder_checker.sv]
// ============================================================================
// utf8_to_utf16_transcoder_checker
// Watches the byte and code unit channels and the APB port of the transcoder.
// Each byte taken is decoded by a local UTF-8 to UTF-16 model. The model keeps
// its own copy of the unit limit and of the decoder state. The code units that
// should follow are queued, and each unit the block delivers is compared with
// the oldest queued one.
// ============================================================================
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8u16_pkg::ADDR_W-1:0]    paddr,
    input  logic [u8u16_pkg::DATA_W-1:0]    pwdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [7:0]                      in_byte,
    input  logic                            last,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [15:0]                     code_unit,
    input  logic                            is_end,
    output int                              errors,
    output int                              waiting,
    output int                              checked
);

    localparam logic [u8u16_pkg::ADDR_W-1:0] LIMIT_ADDR = {u8u16_pkg::REG_UNIT_LIMIT, 2'b00};

    typedef struct packed {
        logic [15:0] unit;
        logic        term;
    } unit_item_t;

    // Decoder state as seen from outside
    logic [15:0]  limit_q;
    logic [7:0]   held [0:2];
    int unsigned  held_n;
    int unsigned  units_n;
    bit           stopped;
    bit           ended;
    unit_item_t   units_due [$];

    // Bytes in a sequence led by this byte, 0 when it cannot lead
    function automatic int unsigned lead_span(input logic [7:0] b);
        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            return 2;
        end
        if (b >= 8'hE0 && b <= 8'hEF)
        begin
            return 3;
        end
        if (b >= 8'hF0 && b <= 8'hF4)
        begin
            return 4;
        end
        return 0;
    endfunction

    // One code unit, subject to the limit
    task automatic queue_unit(input logic [15:0] u);
        if (stopped)
        begin
            return;
        end
        if (units_n >= limit_q)
        begin
            stopped = 1'b1;
            return;
        end
        units_due.push_back({u, 1'b0});
        units_n++;
    endtask

    // Surrogate pair; both halves must fit
    task automatic queue_pair(input logic [20:0] cp);
        logic [20:0] v;
        if (stopped)
        begin
            return;
        end
        if (units_n + 2 > limit_q)
        begin
            stopped = 1'b1;
            return;
        end
        v = cp - u8u16_pkg::CP_MIN4;
        units_due.push_back({u8u16_pkg::HI_SURR_BASE | {6'd0, v[19:10]}, 1'b0});
        units_due.push_back({u8u16_pkg::LO_SURR_BASE | {6'd0, v[9:0]}, 1'b0});
        units_n += 2;
    endtask

    // Each held byte turns into a replacement unit
    task automatic flush_held();
        repeat (held_n) queue_unit(u8u16_pkg::CP_REPL);
        held_n = 0;
    endtask

    // Byte seen with nothing held
    task automatic take_fresh(input logic [7:0] b);
        if (b < 8'h80)
        begin
            queue_unit({8'd0, b});
        end
        else if (lead_span(b) != 0)
        begin
            held[0] = b;
            held_n  = 1;
        end
        else
        begin
            queue_unit(u8u16_pkg::CP_REPL);
        end
    endtask

    // Final continuation byte: assemble and range-check the code point
    task automatic close_sequence(input logic [7:0] b, input int unsigned len);
        logic [20:0] cp;
        bit          ok;
        if (len == 2)
        begin
            cp = {10'd0, held[0][4:0], b[5:0]};
            ok = 1'b1;
        end
        else if (len == 3)
        begin
            cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
            ok = cp >= u8u16_pkg::CP_MIN3 &&
                 !(cp >= u8u16_pkg::CP_SURR_LO && cp <= u8u16_pkg::CP_SURR_HI);
        end
        else
        begin
            cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
            ok = cp >= u8u16_pkg::CP_MIN4 && cp <= u8u16_pkg::CP_MAX;
        end
        held_n = 0;
        if (!ok)
        begin
            repeat (len) queue_unit(u8u16_pkg::CP_REPL);
        end
        else if (cp <= u8u16_pkg::CP_BMP_MAX)
        begin
            queue_unit(cp[15:0]);
        end
        else
        begin
            queue_pair(cp);
        end
    endtask

    task automatic close_string();
        flush_held();
        units_due.push_back({16'd0, 1'b1});
        ended = 1'b1;
    endtask

    // Code units caused by one byte taken
    task automatic predict_units(input logic [7:0] b, input logic fin);
        int unsigned len;
        if (ended)
        begin
            return;
        end
        if (b == 8'd0)
        begin
            close_string();
            return;
        end
        if (held_n > 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                len = lead_span(held[0]);
                if (held_n + 1 >= len)
                begin
                    close_sequence(b, len);
                end
                else if (held_n < 3)
                begin
                    held[held_n] = b;
                    held_n++;
                end
            end
            else
            begin
                flush_held();
                take_fresh(b);
            end
        end
        else if (b[7:6] == 2'b10)
        begin
            queue_unit(u8u16_pkg::CP_REPL);
        end
        else
        begin
            take_fresh(b);
        end
        if (fin)
        begin
            close_string();
        end
    endtask

    // Compare one delivered item with the oldest one due
    task automatic compare_unit();
        unit_item_t due;
        if (units_due.size() == 0)
        begin
            $error("unexpected item: code_unit %h is_end %b", code_unit, is_end);
            errors++;
            return;
        end
        due = units_due.pop_front();
        checked++;
        if (code_unit !== due.unit)
        begin
            $error("code_unit: expected %h, got %h", due.unit, code_unit);
            errors++;
        end
        if (is_end !== due.term)
        begin
            $error("is_end: expected %b, got %b", due.term, is_end);
            errors++;
        end
    endtask

    // Everything is sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_q = u8u16_pkg::UNIT_LIMIT_RST;
            held_n  = 0;
            units_n = 0;
            stopped = 1'b0;
            ended   = 1'b0;
            units_due.delete();
            errors  = 0;
            waiting = 0;
            checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
            begin
                limit_q = pwdata[15:0];
            end
            if (out_valid && !out_stall)
            begin
                compare_unit();
            end
            if (in_valid && !in_stall)
            begin
                predict_units(in_byte, last);
            end
            waiting = units_due.size();
        end
    end

endmodule

[dv/utf8_to_utf16_transcoder_top_tb.sv]
// ============================================================================
// utf8_to_utf16_transcoder_top_tb
// Feeds one long UTF-8 string to the transcoder. A directed part comes first,
// at the reset limit. A random part follows under the widest limit: mostly
// well-formed characters, plus raw, cut and noise bytes. Last come tight limits
// that stop the output, then the end of the string and bytes after it. Both
// sides idle at random. The checker does all comparison.
// ============================================================================
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_top_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 20;
    localparam int RANDOM_BYTES = 430;
    localparam logic [u8u16_pkg::ADDR_W-1:0] LIMIT_ADDR = {u8u16_pkg::REG_UNIT_LIMIT, 2'b00};

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [u8u16_pkg::ADDR_W-1:0]   paddr;
    logic [u8u16_pkg::DATA_W-1:0]   pwdata;
    logic [u8u16_pkg::DATA_W-1:0]   prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic [7:0]                     in_byte;
    logic                           last;
    logic                           out_valid;
    logic                           out_stall;
    logic [15:0]                    code_unit;
    logic                           is_end;

    int  errors;
    int  waiting;
    int  checked;
    int  bytes_sent;
    int  units_seen;
    int  cycles;
    bit  calm;

    utf8_to_utf16_transcoder_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .is_end    (is_end)
    );

    utf8_to_utf16_transcoder_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .is_end    (is_end),
        .errors    (errors),
        .waiting   (waiting),
        .checked   (checked)
    );

    always #2 clk = ~clk;

    // Watchdog and count of code units delivered so far
    always @(posedge clk)
    begin
        cycles++;
        if (out_valid && !out_stall && !is_end)
        begin
            units_seen++;
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("utf8_to_utf16_transcoder_top: mismatch");
            $finish;
        end
    end

    // Receiver: random stall before each item, none while calm
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // One byte item; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= fin;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    // UTF-8 form of a code point, cut to its first keep bytes
    task automatic send_char(input logic [20:0] cp, input int keep);
        logic [7:0] enc [0:3];
        int         n;
        if (cp < 21'h80)
        begin
            enc[0] = cp[7:0];
            n = 1;
        end
        else if (cp < 21'h800)
        begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            n = 2;
        end
        else if (cp < 21'h10000)
        begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            n = 3;
        end
        else
        begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        if (keep < n)
        begin
            n = keep;
        end
        for (int i = 0; i < n; i++)
        begin
            send_byte(enc[i], 1'b0);
        end
    endtask

    // Stop sending until every unit due has come and the pipe is quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_limit(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [20:0] pick_code_point();
        case ($urandom_range(0, 3))
            0: return 21'($urandom_range(21'h01, 21'h7F));
            1: return 21'($urandom_range(21'h80, 21'h7FF));
            2: return 21'($urandom_range(21'h800, 21'hFFFF));
            default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
    endfunction

    // Main sequence
    initial
    begin
        int          kind;
        int          conts;
        bit          paused;
        logic [20:0] cp;
        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        in_byte    = 8'd0;
        last       = 1'b0;
        calm       = 1'b0;
        paused     = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, at the reset limit: range edges of each length
        send_byte(8'h7F, 1'b0);
        send_char(21'h00080, 4);
        send_char(21'h00800, 4);
        send_char(21'h0FFFF, 4);
        send_char(21'h10000, 4);
        send_char(21'h10FFFF, 4);
        // bad lead, lone continuation
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // surrogate, above 0x10FFFF
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // short sequence broken by ASCII
        send_char(21'h10000, 3);
        send_byte(8'h41, 1'b0);
        drain();

        // Random body under the widest limit
        write_limit(16'hFFFF);
        while (bytes_sent < RANDOM_BYTES)
        begin
            calm = bytes_sent >= 180 && bytes_sent < 260;
            if (!paused && bytes_sent >= 320)
            begin
                paused = 1'b1;
                drain();
            end
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                send_char(pick_code_point(), 4);
            end
            else if (kind < 75)
            begin
                // raw lead with random continuations: overlong, bad, short
                send_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
                conts = $urandom_range(0, 3);
                repeat (conts) send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
            else if (kind < 87)
            begin
                cp = 21'($urandom_range(21'h80, 21'h10FFFF));
                send_char(cp, $urandom_range(1, 3));
            end
            else
            begin
                send_byte(8'($urandom_range(8'h01, 8'hFF)), 1'b0);
            end
        end
        calm = 1'b0;
        drain();

        // Exact fit: one unit and a pair land right on the limit
        write_limit(16'(units_seen + 3));
        send_byte(8'h41, 1'b0);
        send_char(21'h1F600, 4);
        drain();

        // Pair that does not fit stops the output for good
        write_limit(16'(units_seen + 1));
        send_char(21'h1F600, 4);
        send_byte(8'h42, 1'b0);
        drain();

        // Zero limit, held bytes at the end, zero byte marked last
        write_limit(16'd0);
        send_byte(8'h43, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h00, 1'b1);

        // Bytes after the end give nothing
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain();

        $display("Sent %0d bytes under limits 255, 65535, exact fit, overflow and 0;",
                 bytes_sent);
        $display("%0d items compared, %0d code units seen.", checked, units_seen);
        if (errors == 0 && waiting == 0)
        begin
            $display("utf8_to_utf16_transcoder_top: match");
        end
        else
        begin
            $display("utf8_to_utf16_transcoder_top: mismatch");
        end
        $finish;
    end

endmodule
